@@ rtl/core/ivsb_pkg.sv @@
package ivsb_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int PIX_W        = 3 * CHANNEL_BITS;
  localparam int CFG_W        = 3;
  localparam int RUN_MAX      = 4;
  localparam int CNT_W        = $clog2(RUN_MAX + 1);
  localparam int IDX_W        = $clog2(RUN_MAX);

  localparam logic CFG_SCALE_MODE  = 1'b0;
  localparam logic CFG_FRAME_BLEND = 1'b1;

  typedef enum logic [2:0] {
    MODE_1X      = 3'd0,
    MODE_2X      = 3'd1,
    MODE_2X_SCAN = 3'd2,
    MODE_3X      = 3'd3,
    MODE_4X      = 3'd4
  } mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] cur_left;
    logic [PIX_W-1:0] cur_right;
    logic [PIX_W-1:0] old_left;
    logic [PIX_W-1:0] old_right;
    logic [1:0]       row_copy;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic [2:0] scale_mode;
    logic       frame_blend;
  } cfg_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][PIX_W-1:0] pix;
    logic [CNT_W-1:0]              cnt;
  } run_t;

  function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    logic [CHANNEL_BITS:0] s;
    logic [PIX_W-1:0]      r;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      s = {1'b0, a[k*CHANNEL_BITS +: CHANNEL_BITS]} +
          {1'b0, b[k*CHANNEL_BITS +: CHANNEL_BITS]};
      r[k*CHANNEL_BITS +: CHANNEL_BITS] = s[CHANNEL_BITS:1];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c,
                                            input logic [PIX_W-1:0] d);
    logic [CHANNEL_BITS+1:0] s;
    logic [PIX_W-1:0]        r;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      s = {2'b00, a[k*CHANNEL_BITS +: CHANNEL_BITS]} +
          {2'b00, b[k*CHANNEL_BITS +: CHANNEL_BITS]} +
          {2'b00, c[k*CHANNEL_BITS +: CHANNEL_BITS]} +
          {2'b00, d[k*CHANNEL_BITS +: CHANNEL_BITS]};
      r[k*CHANNEL_BITS +: CHANNEL_BITS] = s[CHANNEL_BITS+1:2];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] halve(input logic [PIX_W-1:0] p);
    logic [PIX_W-1:0] r;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      r[k*CHANNEL_BITS +: CHANNEL_BITS] =
        {1'b0, p[k*CHANNEL_BITS+1 +: CHANNEL_BITS-1]};
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ivsb_expand.sv @@
module ivsb_expand (
  input  ivsb_pkg::in_t  item,
  input  ivsb_pkg::cfg_t cfg,
  output ivsb_pkg::run_t run
);

  logic [ivsb_pkg::PIX_W-1:0] l;
  logic [ivsb_pkg::PIX_W-1:0] r;
  logic [ivsb_pkg::PIX_W-1:0] mid;
  logic [ivsb_pkg::PIX_W-1:0] sl;
  logic [ivsb_pkg::PIX_W-1:0] sr;

  always_comb begin
    l   = cfg.frame_blend ? ivsb_pkg::avg2(item.cur_left, item.old_left) : item.cur_left;
    r   = cfg.frame_blend ? ivsb_pkg::avg2(item.cur_right, item.old_right) : item.cur_right;
    mid = cfg.frame_blend ?
          ivsb_pkg::avg4(item.cur_left, item.old_left, item.cur_right, item.old_right) :
          ivsb_pkg::avg2(item.cur_left, item.cur_right);
    // odd rows darkened in scanline mode
    sl  = item.row_copy[0] ? ivsb_pkg::halve(item.cur_left) : item.cur_left;
    sr  = item.row_copy[0] ? ivsb_pkg::halve(item.cur_right) : item.cur_right;
  end

  always_comb begin
    run.pix = '0;
    run.cnt = '0;
    unique case (cfg.scale_mode)
      ivsb_pkg::MODE_1X: begin
        run.pix[0] = ivsb_pkg::avg2(item.cur_left, item.cur_right);
        run.cnt    = ivsb_pkg::CNT_W'(1);
      end
      ivsb_pkg::MODE_2X: begin
        run.pix[0] = l;
        run.pix[1] = r;
        run.cnt    = ivsb_pkg::CNT_W'(2);
      end
      ivsb_pkg::MODE_2X_SCAN: begin
        run.pix[0] = sl;
        run.pix[1] = sr;
        run.cnt    = ivsb_pkg::CNT_W'(2);
      end
      ivsb_pkg::MODE_3X: begin
        run.pix[0] = l;
        run.pix[1] = mid;
        run.pix[2] = r;
        run.cnt    = ivsb_pkg::CNT_W'(3);
      end
      ivsb_pkg::MODE_4X: begin
        run.pix[0] = l;
        run.pix[1] = l;
        run.pix[2] = r;
        run.pix[3] = r;
        run.cnt    = ivsb_pkg::CNT_W'(4);
      end
      default: begin
        run.cnt = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/integer_video_scaler_blend.sv @@
// a result appears on dst after its item has passed the input register, compute
// register, run register and output register, in that order
// throughput: one result per cycle while dst is not stalled; the run register
// emits each item's scale_mode run of 1 to 4 pixels one pixel at a time
// reset: synchronous; clears all valid bits, scale_mode to 2x, frame_blend off
module integer_video_scaler_blend (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       src_valid,
  output logic                       src_stall,
  input  ivsb_pkg::in_t              src_item,
  output logic                       dst_valid,
  input  logic                       dst_stall,
  output ivsb_pkg::out_t             dst_item,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [ivsb_pkg::CFG_W-1:0] cfg_data
);

  ivsb_pkg::cfg_t cfg;

  logic           s1_valid;
  ivsb_pkg::in_t  s1_item;
  logic           s2_valid;
  ivsb_pkg::run_t s2_run;
  logic           s3_valid;
  ivsb_pkg::run_t s3_run;
  logic [ivsb_pkg::IDX_W-1:0] s3_idx;

  ivsb_pkg::run_t calc_run;

  logic s1_ready;
  logic s2_ready;
  logic s3_free;
  logic s3_emit;
  logic s3_last;
  logic s3_load;
  logic out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_mode  <= ivsb_pkg::MODE_2X;
      cfg.frame_blend <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ivsb_pkg::CFG_SCALE_MODE:  cfg.scale_mode  <= cfg_data;
        ivsb_pkg::CFG_FRAME_BLEND: cfg.frame_blend <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ivsb_expand u_expand (
    .item (s1_item),
    .cfg  (cfg),
    .run  (calc_run)
  );

  always_comb begin
    out_free  = !dst_valid || !dst_stall;
    s3_emit   = s3_valid && out_free;
    s3_last   = ({1'b0, s3_idx} + ivsb_pkg::CNT_W'(1)) == s3_run.cnt;
    s3_free   = !s3_valid || (s3_emit && s3_last);
    s3_load   = s2_valid && s3_free;
    s2_ready  = !s2_valid || s3_free;
    s1_ready  = !s1_valid || s2_ready;
    src_stall = !s1_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_item <= src_item;
    end
  end

  // modes without output drop the item here
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && (calc_run.cnt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_run <= calc_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s3_idx   <= '0;
    end else if (s3_load) begin
      s3_valid <= 1'b1;
      s3_idx   <= '0;
    end else if (s3_emit) begin
      if (s3_last) begin
        s3_valid <= 1'b0;
      end else begin
        s3_idx <= s3_idx + ivsb_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_run <= s2_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_free) begin
      dst_valid <= s3_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      dst_item.out_pixel   <= s3_run.pix[s3_idx];
      dst_item.last_of_run <= s3_last;
    end
  end

  a_run_index: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> ({1'b0, s3_idx} < s3_run.cnt))
    else $error("run index past run length");

  a_no_empty_run: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_run.cnt != '0))
    else $error("empty run held in compute register");

  a_run_retire: assert property (@(posedge clk) disable iff (rst)
    (s3_emit && s3_last && !s3_load) |=> !s3_valid)
    else $error("run register kept a finished run");

  a_emit_shown: assert property (@(posedge clk) disable iff (rst)
    s3_emit |=> dst_valid)
    else $error("emitted pixel not shown");

endmodule

@@ bench/integer_video_scaler_blend_checker.sv @@
module integer_video_scaler_blend_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       src_valid,
  input  logic                       src_stall,
  input  ivsb_pkg::in_t              src_item,
  input  logic                       dst_valid,
  input  logic                       dst_stall,
  input  ivsb_pkg::out_t             dst_item,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [ivsb_pkg::CFG_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = ivsb_pkg::CHANNEL_BITS;
  localparam int PW = ivsb_pkg::PIX_W;

  logic [2:0]     mode_q;
  logic           blend_q;
  ivsb_pkg::out_t pixels_due[$];

  // per-channel sum of up to four pixels, shifted right, no carry across channels
  function automatic logic [PW-1:0] chan_mix(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b,
                                             input logic [PW-1:0] c,
                                             input logic [PW-1:0] d,
                                             input int sh);
    logic [PW-1:0] r;
    int s;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      s = int'(a[k*CB +: CB]) + int'(b[k*CB +: CB]) +
          int'(c[k*CB +: CB]) + int'(d[k*CB +: CB]);
      r[k*CB +: CB] = CB'(s >> sh);
    end
    return r;
  endfunction

  function automatic void push_due(input logic [PW-1:0] p, input logic last);
    pixels_due.push_back(ivsb_pkg::out_t'{p, last});
  endfunction

  task automatic queue_run(input ivsb_pkg::in_t it);
    logic [PW-1:0] nil, lp, rp, mid;
    nil = '0;
    lp = blend_q ? chan_mix(it.cur_left, it.old_left, nil, nil, 1) : it.cur_left;
    rp = blend_q ? chan_mix(it.cur_right, it.old_right, nil, nil, 1) : it.cur_right;
    case (mode_q)
      ivsb_pkg::MODE_1X: begin
        push_due(chan_mix(it.cur_left, it.cur_right, nil, nil, 1), 1'b1);
      end
      ivsb_pkg::MODE_2X: begin
        push_due(lp, 1'b0);
        push_due(rp, 1'b1);
      end
      ivsb_pkg::MODE_2X_SCAN: begin
        // odd rows are darkened, blend never applies
        if (it.row_copy[0]) begin
          push_due(chan_mix(it.cur_left, nil, nil, nil, 1), 1'b0);
          push_due(chan_mix(it.cur_right, nil, nil, nil, 1), 1'b1);
        end else begin
          push_due(it.cur_left, 1'b0);
          push_due(it.cur_right, 1'b1);
        end
      end
      ivsb_pkg::MODE_3X: begin
        mid = blend_q ? chan_mix(it.cur_left, it.old_left, it.cur_right, it.old_right, 2)
                      : chan_mix(it.cur_left, it.cur_right, nil, nil, 1);
        push_due(lp, 1'b0);
        push_due(mid, 1'b0);
        push_due(rp, 1'b1);
      end
      ivsb_pkg::MODE_4X: begin
        push_due(lp, 1'b0);
        push_due(lp, 1'b0);
        push_due(rp, 1'b0);
        push_due(rp, 1'b1);
      end
      default: begin
        // unused modes emit nothing
      end
    endcase
  endtask

  always @(posedge clk) begin
    ivsb_pkg::out_t want;
    if (rst) begin
      mode_q = ivsb_pkg::MODE_2X;
      blend_q = 1'b0;
      errors = 0;
      pixels_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == ivsb_pkg::CFG_SCALE_MODE) begin
          mode_q = cfg_data;
        end else begin
          blend_q = cfg_data[0];
        end
      end
      if (src_valid && !src_stall) begin
        queue_run(src_item);
      end
      if (dst_valid && !dst_stall) begin
        if (pixels_due.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected result: pixel %06h last %0d",
                     dst_item.out_pixel, dst_item.last_of_run);
          end
          errors++;
        end else begin
          want = pixels_due.pop_front();
          if (want.out_pixel !== dst_item.out_pixel ||
              want.last_of_run !== dst_item.last_of_run) begin
            if (errors < 10) begin
              $display("mismatch: expected pixel %06h last %0d, got pixel %06h last %0d",
                       want.out_pixel, want.last_of_run,
                       dst_item.out_pixel, dst_item.last_of_run);
            end
            errors++;
          end
        end
      end
    end
    pending <= pixels_due.size();
  end

endmodule

@@ bench/integer_video_scaler_blend_tb.sv @@
module integer_video_scaler_blend_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int CB          = ivsb_pkg::CHANNEL_BITS;
  localparam int PW          = ivsb_pkg::PIX_W;

  logic                       clk;
  logic                       rst;
  logic                       src_valid;
  logic                       src_stall;
  ivsb_pkg::in_t              src_item;
  logic                       dst_valid;
  logic                       dst_stall;
  ivsb_pkg::out_t             dst_item;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [ivsb_pkg::CFG_W-1:0] cfg_data;

  int errors;
  int pending;
  int snd_pct;
  int rcv_pct;
  bit hold_req;
  int idle_run;

  integer_video_scaler_blend dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  integer_video_scaler_blend_checker chk (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    dst_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        dst_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        dst_stall <= ($urandom_range(99) < rcv_pct);
      end
    end
  end

  initial begin
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("integer_video_scaler_blend regression: fail");
    $finish;
  end

  function automatic logic [PW-1:0] rand_pixel();
    logic [PW-1:0] p;
    p = PW'($urandom());
    if ($urandom_range(3) == 0) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(2))
          0: p[k*CB +: CB] = '0;
          1: p[k*CB +: CB] = '1;
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  function automatic ivsb_pkg::in_t rand_item();
    ivsb_pkg::in_t it;
    it.cur_left  = rand_pixel();
    it.cur_right = rand_pixel();
    it.old_left  = ($urandom_range(7) == 0) ? it.cur_left : rand_pixel();
    it.old_right = rand_pixel();
    it.row_copy  = 2'($urandom_range(3));
    return it;
  endfunction

  function automatic ivsb_pkg::in_t pattern_item(input int k);
    ivsb_pkg::in_t it;
    case (k % 6)
      0: it = '{'0, '0, '0, '0, 2'd0};
      1: it = '{'1, '1, '1, '1, 2'd1};
      2: it = '{'1, '0, '0, '1, 2'd2};
      3: it = '{24'h010203, 24'h000000, 24'h030201, 24'hfefdfc, 2'd3};
      4: it = '{24'h80ff7f, 24'h7f0180, 24'hff00ff, 24'h00ff00, 2'd1};
      default: it = rand_item();
    endcase
    return it;
  endfunction

  task automatic send_pair(input ivsb_pkg::in_t it);
    @(negedge clk);
    while ($urandom_range(99) < snd_pct) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    @(posedge clk);
    while (src_stall) @(posedge clk);
  endtask

  // sender goes quiet until every pending pixel is out, then the pipe settles
  task automatic drain();
    @(negedge clk);
    src_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input logic [2:0] m, input bit b);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ivsb_pkg::CFG_SCALE_MODE;
    cfg_data  <= m;
    @(negedge clk);
    cfg_index <= ivsb_pkg::CFG_FRAME_BLEND;
    cfg_data  <= ivsb_pkg::CFG_W'({$urandom_range(3), b});
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    src_valid = 1'b0;
    src_item  = '0;
    cfg_we    = 1'b0;
    cfg_index = ivsb_pkg::CFG_SCALE_MODE;
    cfg_data  = '0;
    snd_pct   = 0;
    rcv_pct   = 0;
    hold_req  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults
    send_pair(pattern_item(0));
    send_pair(pattern_item(1));
    for (int c = 0; c < 10; c++) begin
      drain();
      set_config(3'(c / 2), bit'(c % 2));
      send_pair(pattern_item(2 * c));
      send_pair(pattern_item(2 * c + 1));
    end
    for (int m = 5; m < 8; m++) begin
      drain();
      set_config(3'(m), bit'($urandom_range(1)));
      send_pair(rand_item());
    end

    for (int ph = 0; ph < 16; ph++) begin
      drain();
      if (ph % 6 == 5) begin
        set_config(3'($urandom_range(7, 5)), bit'($urandom_range(1)));
        repeat (6) send_pair(rand_item());
        drain();
      end
      case (ph % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 71; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 71; end
        default: begin snd_pct = 8; rcv_pct = 8; end
      endcase
      if (ph < 10) begin
        set_config(3'(ph % 5), bit'((ph / 5) % 2));
      end else begin
        set_config(3'($urandom_range(4)), bit'($urandom_range(1)));
      end
      if (ph == 2) hold_req = 1'b1;
      repeat (22) send_pair(rand_item());
    end
    drain();

    if (errors == 0 && pending == 0) begin
      $display("integer_video_scaler_blend regression: pass");
    end else begin
      $display("integer_video_scaler_blend regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ivsb_pkg.sv
rtl/core/ivsb_expand.sv
rtl/core/integer_video_scaler_blend.sv
bench/integer_video_scaler_blend_checker.sv
bench/integer_video_scaler_blend_tb.sv
